// ----- rtl/socf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package socf_pkg;

   localparam int ANGLE_W      = 32;
   localparam int DT_W         = 16;
   localparam int TC_W         = 16;
   localparam int REQ_TDATA_W  = 2 * ANGLE_W + DT_W;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = ANGLE_W;
   localparam int RSP_TUSER_W  = 2;

   localparam logic [TC_W-1:0] TC_RESET = 16'd1792;

   localparam logic REQ_INIT   = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MP,
      OP_MB,
      OP_MA,
      OP_MPROP,
      OP_MINT,
      OP_TERM,
      OP_ABS,
      OP_TLO,
      OP_THI,
      OP_DA,
      OP_FIN
   } dp_op_type;

   typedef struct packed {
      logic      capture;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- rtl/socf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module socf_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   input  wire                     req_init,
   output logic                    req_tready,
   input  wire socf_pkg::dp_status_type status,
   output socf_pkg::dp_cmd_type    cmd
);
   import socf_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE  = 13'h0001,
      ST_LOAD  = 13'h0002,
      ST_MP    = 13'h0004,
      ST_MB    = 13'h0008,
      ST_MA    = 13'h0010,
      ST_MPROP = 13'h0020,
      ST_MINT  = 13'h0040,
      ST_TERM  = 13'h0080,
      ST_ABS   = 13'h0100,
      ST_TLO   = 13'h0200,
      ST_THI   = 13'h0400,
      ST_DA    = 13'h0800,
      ST_FIN   = 13'h1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.op      = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = req_init ? ST_FIN : ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.op   = OP_LOAD;
            state_in = ST_MP;
         end
         ST_MP: begin
            cmd.op   = OP_MP;
            state_in = ST_MB;
         end
         ST_MB: begin
            cmd.op   = OP_MB;
            state_in = ST_MA;
         end
         ST_MA: begin
            cmd.op   = OP_MA;
            state_in = ST_MPROP;
         end
         ST_MPROP: begin
            cmd.op   = OP_MPROP;
            state_in = ST_MINT;
         end
         ST_MINT: begin
            cmd.op   = OP_MINT;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            cmd.op   = OP_TERM;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            cmd.op   = OP_ABS;
            state_in = ST_TLO;
         end
         ST_TLO: begin
            cmd.op   = OP_TLO;
            state_in = ST_THI;
         end
         ST_THI: begin
            cmd.op   = OP_THI;
            state_in = ST_DA;
         end
         ST_DA: begin
            cmd.op   = OP_DA;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.op   = OP_FIN;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_fin_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && !status.out_free) |=> state_ff == ST_FIN)
      else $error("result committed while output register busy");

   a_update_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid && !req_init) |=> state_ff == ST_LOAD)
      else $error("update word did not start the filter sequence");

   a_init_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid && req_init) |=> state_ff == ST_FIN)
      else $error("init word did not go straight to commit");

endmodule
`default_nettype wire

// ----- rtl/socf_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module socf_dp (
   input  wire                                clock,
   input  wire                                reset,
   input  wire socf_pkg::dp_cmd_type          cmd,
   output socf_pkg::dp_status_type            status,
   input  wire                                req_type,
   input  wire                                req_axis,
   input  wire [socf_pkg::ANGLE_W-1:0]        req_accel,
   input  wire [socf_pkg::ANGLE_W-1:0]        req_rate,
   input  wire [socf_pkg::DT_W-1:0]           req_dt,
   input  wire                                csr_wr_en,
   input  wire [socf_pkg::TC_W-1:0]           csr_wr_data,
   input  wire                                rsp_tready,
   output logic                               rsp_tvalid,
   output logic [socf_pkg::ANGLE_W-1:0]       rsp_angle,
   output logic                               rsp_axis,
   output logic                               rsp_sat
);
   import socf_pkg::*;

   localparam int ERR_W  = ANGLE_W + 1;
   localparam int PROD_W = 2 * ANGLE_W;
   localparam int PART_W = ANGLE_W + DT_W;
   localparam int DI_W   = ANGLE_W + 1;
   localparam int PROP_W = 42;
   localparam int TERM_W = 44;
   localparam int TM_W   = 43;
   localparam int DA_W   = 45;
   localparam int WIDE_W = 48;

   localparam logic [PART_W+1:0] RND48 = {2'b00, 1'b1, {(PART_W-1){1'b0}}};

   function automatic logic [ANGLE_W:0] sat32(input logic [WIDE_W-1:0] v);
      logic [WIDE_W-ANGLE_W:0] upper;
      upper = v[WIDE_W-1:ANGLE_W-1];
      if ((&upper) || !(|upper)) begin
         return {1'b0, v[ANGLE_W-1:0]};
      end else if (v[WIDE_W-1]) begin
         return {1'b1, 1'b1, {(ANGLE_W-1){1'b0}}};
      end else begin
         return {1'b1, 1'b0, {(ANGLE_W-1){1'b1}}};
      end
   endfunction

   // state; angle and integrator reset to zero, time constant to TC_RESET
   logic [ANGLE_W-1:0] angle_store_ff [2];
   logic [ANGLE_W-1:0] integ_store_ff [2];
   logic [TC_W-1:0]    tc_ff;

   // captured word
   logic               type_ff;
   logic               axis_ff;
   logic [ANGLE_W-1:0] accel_ff;
   logic [ANGLE_W-1:0] rate_ff;
   logic [DT_W-1:0]    dt_ff;

   // work registers
   logic [ANGLE_W-1:0] prev_ff;
   logic [ANGLE_W-1:0] integ_ff;
   logic [ANGLE_W-1:0] em_ff;
   logic               eneg_ff;
   logic [PROD_W-1:0]  mul_ff;
   logic [PROD_W-1:0]  p_ff;
   logic [PART_W-1:0]  b_ff;
   logic [DI_W-1:0]    di_ff;
   logic [PROP_W-1:0]  prop_ff;
   logic               sat_ff;
   logic [TERM_W-1:0]  term_ff;
   logic [TM_W-1:0]    tm_ff;
   logic               tneg_ff;
   logic [DA_W-1:0]    da_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_W-1:0] rsp_angle_ff;
   logic               rsp_axis_ff;
   logic               rsp_sat_ff;

   logic [ANGLE_W-1:0] rd_angle, rd_integ;
   logic [ERR_W-1:0]   err, err_neg;
   logic [ANGLE_W-1:0] err_mag;
   logic [ANGLE_W-1:0] mul_a, mul_b;
   logic [PART_W+1:0]  di_low;
   logic [DI_W-1:0]    di_mag;
   logic [WIDE_W-1:0]  di_s, integ_sum;
   logic [ANGLE_W:0]   integ_sat;
   logic [PROD_W/2+DT_W+1:0] prop_sum;
   logic [TERM_W-1:0]  prop_s, term_sum, term_neg;
   logic [PART_W:0]    bsum;
   logic [DA_W-1:0]    da_sum;
   logic [WIDE_W-1:0]  da_s, ang_sum;
   logic [ANGLE_W:0]   ang_sat;
   logic               fin;

   assign fin = (cmd.op == OP_FIN);

   always_comb begin
      rd_angle = angle_store_ff[axis_ff];
      rd_integ = integ_store_ff[axis_ff];
      err      = {accel_ff[ANGLE_W-1], accel_ff} - {rd_angle[ANGLE_W-1], rd_angle};
      err_neg  = -err;
      err_mag  = err[ERR_W-1] ? err_neg[ANGLE_W-1:0] : err[ANGLE_W-1:0];
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_LOAD: begin
            mul_a = {{(ANGLE_W-TC_W){1'b0}}, tc_ff};
            mul_b = {{(ANGLE_W-TC_W){1'b0}}, tc_ff};
         end
         OP_MP: begin
            mul_a = em_ff;
            mul_b = mul_ff[ANGLE_W-1:0];
         end
         OP_MB: begin
            mul_a = mul_ff[ANGLE_W-1:0];
            mul_b = {{(ANGLE_W-DT_W){1'b0}}, dt_ff};
         end
         OP_MA: begin
            mul_a = p_ff[PROD_W-1:ANGLE_W];
            mul_b = {{(ANGLE_W-DT_W){1'b0}}, dt_ff};
         end
         OP_MPROP: begin
            mul_a = em_ff;
            mul_b = {{(ANGLE_W-TC_W){1'b0}}, tc_ff};
         end
         OP_TLO: begin
            mul_a = tm_ff[ANGLE_W-1:0];
            mul_b = {{(ANGLE_W-DT_W){1'b0}}, dt_ff};
         end
         OP_THI: begin
            mul_a = {{(2*ANGLE_W-TM_W){1'b0}}, tm_ff[TM_W-1:ANGLE_W]};
            mul_b = {{(ANGLE_W-DT_W){1'b0}}, dt_ff};
         end
         OP_NONE, OP_MINT, OP_TERM, OP_ABS, OP_DA, OP_FIN: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      // integrator step: round(p * dt / 2^48), a in mul_ff, b in b_ff
      di_low = {2'b00, mul_ff[DT_W-1:0], {ANGLE_W{1'b0}}} + {2'b00, b_ff} + RND48;
      di_mag = {1'b0, mul_ff[PART_W-1:DT_W]} + {{(DI_W-2){1'b0}}, di_low[PART_W+1:PART_W]};
      di_s   = eneg_ff ? -{{(WIDE_W-DI_W){1'b0}}, di_ff} : {{(WIDE_W-DI_W){1'b0}}, di_ff};
      integ_sum = {{(WIDE_W-ANGLE_W){integ_ff[ANGLE_W-1]}}, integ_ff} + di_s;
      integ_sat = sat32(integ_sum);

      // proportional: round(2 * e * tc / 2^8)
      prop_sum = {1'b0, mul_ff[PART_W-1:0], 1'b0} + 50'h80;
      prop_s   = eneg_ff ? -{{(TERM_W-PROP_W){1'b0}}, prop_ff}
                         : {{(TERM_W-PROP_W){1'b0}}, prop_ff};
      term_sum = {{(TERM_W-ANGLE_W){integ_ff[ANGLE_W-1]}}, integ_ff} + prop_s
               + {{(TERM_W-ANGLE_W){rate_ff[ANGLE_W-1]}}, rate_ff};
      term_neg = -term_ff;

      // angle step: round(term * dt / 2^16)
      bsum   = {1'b0, b_ff} + 49'h8000;
      da_sum = {mul_ff[DA_W-DT_W-1:0], {DT_W{1'b0}}}
             + {{(DA_W-(PART_W+1-DT_W)){1'b0}}, bsum[PART_W:DT_W]};
      da_s   = tneg_ff ? -{{(WIDE_W-DA_W){1'b0}}, da_ff} : {{(WIDE_W-DA_W){1'b0}}, da_ff};
      ang_sum = {{(WIDE_W-ANGLE_W){prev_ff[ANGLE_W-1]}}, prev_ff} + da_s;
      ang_sat = sat32(ang_sum);
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      if (cmd.capture) begin
         type_ff  <= req_type;
         axis_ff  <= req_axis;
         accel_ff <= req_accel;
         rate_ff  <= req_rate;
         dt_ff    <= req_dt;
      end
      unique case (cmd.op)
         OP_LOAD: begin
            prev_ff  <= rd_angle;
            integ_ff <= rd_integ;
            em_ff    <= err_mag;
            eneg_ff  <= err[ERR_W-1];
         end
         OP_MB: begin
            p_ff <= mul_ff;
         end
         OP_MA, OP_THI: begin
            b_ff <= mul_ff[PART_W-1:0];
         end
         OP_MPROP: begin
            di_ff <= di_mag;
         end
         OP_MINT: begin
            integ_ff <= integ_sat[ANGLE_W-1:0];
            sat_ff   <= integ_sat[ANGLE_W];
            prop_ff  <= prop_sum[PROP_W+7:8];
         end
         OP_TERM: begin
            term_ff <= term_sum;
         end
         OP_ABS: begin
            tm_ff   <= term_ff[TERM_W-1] ? term_neg[TM_W-1:0] : term_ff[TM_W-1:0];
            tneg_ff <= term_ff[TERM_W-1];
         end
         OP_DA: begin
            da_ff <= da_sum;
         end
         OP_FIN: begin
            rsp_axis_ff <= axis_ff;
            if (type_ff == REQ_INIT) begin
               rsp_angle_ff <= accel_ff;
               rsp_sat_ff   <= 1'b0;
            end else begin
               rsp_angle_ff <= ang_sat[ANGLE_W-1:0];
               rsp_sat_ff   <= sat_ff | ang_sat[ANGLE_W];
            end
         end
         OP_NONE, OP_MP, OP_TLO: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_store_ff <= '{default: '0};
         integ_store_ff <= '{default: '0};
         tc_ff          <= TC_RESET;
      end else begin
         if (csr_wr_en) begin
            tc_ff <= csr_wr_data;
         end
         if (fin) begin
            if (type_ff == REQ_INIT) begin
               angle_store_ff[axis_ff] <= accel_ff;
               integ_store_ff[axis_ff] <= rate_ff;
            end else begin
               angle_store_ff[axis_ff] <= ang_sat[ANGLE_W-1:0];
               integ_store_ff[axis_ff] <= integ_ff;
            end
         end
      end
   end

   assign rsp_valid_in = fin | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.out_free = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_angle       = rsp_angle_ff;
   assign rsp_axis        = rsp_axis_ff;
   assign rsp_sat         = rsp_sat_ff;

   a_zero_dt_hold: assert property (@(posedge clock) disable iff (reset)
      (fin && type_ff == REQ_UPDATE && dt_ff == '0)
      |=> (rsp_angle_ff == $past(prev_ff) && !rsp_sat_ff))
      else $error("zero step time changed the angle");

   a_valid_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fin))
      else $error("result valid raised without a commit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_angle_ff)))
      else $error("result word changed while stalled");

endmodule
`default_nettype wire

// ----- rtl/second_order_complementary_filter.sv -----
// Update word: accept, load, the multiply and add steps, commit to the output register.
// Init word: accept, then commit. In both cases the next word is taken back in idle.
// Update time is set by seven passes through the one shared 32x32 multiplier plus
// the add, round and clamp steps between them; a waiting result stalls only the commit.
// Reset (synchronous, active high) zeroes angle and integrator of both axes,
// sets the time constant to 7.0 and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module second_order_complementary_filter (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // accel_angle, gyro_rate, step_time
   input  wire [socf_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // req_type, axis_sel
   input  wire [socf_pkg::REQ_TUSER_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // angle_estimate
   output logic [socf_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // result_axis, saturated
   output logic [socf_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   input  wire                                  csr_wr_en,
   input  wire [socf_pkg::TC_W-1:0]             csr_wr_data
);
   import socf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_init;
   logic          rsp_axis;
   logic          rsp_sat;

   assign req_init = (req_tuser[0] == REQ_INIT);

   socf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_init   (req_init),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   socf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_type    (req_tuser[0]),
      .req_axis    (req_tuser[1]),
      .req_accel   (req_tdata[ANGLE_W-1:0]),
      .req_rate    (req_tdata[2*ANGLE_W-1:ANGLE_W]),
      .req_dt      (req_tdata[2*ANGLE_W+DT_W-1:2*ANGLE_W]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_angle   (rsp_tdata),
      .rsp_axis    (rsp_axis),
      .rsp_sat     (rsp_sat)
   );

   assign rsp_tuser = {rsp_sat, rsp_axis};

endmodule
`default_nettype wire

// ----- verif/second_order_complementary_filter_tb.sv -----
`timescale 1ns / 1ps
module second_order_complementary_filter_tb;
   import socf_pkg::*;

   localparam int     PHASES      = 8;
   localparam int     PHASE_WORDS = 242;
   localparam int     QUIET_LIMIT = 4000;
   localparam int     PRINT_CAP   = 40;
   localparam longint Q16_MAX     = 64'sd2147483647;
   localparam longint Q16_MIN     = -64'sd2147483648;

   typedef struct packed {
      logic [31:0] angle;
      logic        axis;
      logic        sat;
   } fused_angle_type;

   typedef struct packed {
      logic        kind;
      logic        ax;
      logic [31:0] accel;
      logic [31:0] rate;
      logic [15:0] dt;
      logic        fixed;
      logic [31:0] want_angle;
      logic        want_sat;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_wr_en = 1'b0;
   logic [TC_W-1:0]        csr_wr_data = '0;

   // predictor state
   logic signed [31:0] axis_angle [2];
   logic signed [31:0] axis_integ [2];
   logic [15:0]        tc_model;

   fused_angle_type pending_angles [$];
   plan_row_type    directed_rows [$];
   logic         steady = 1'b0;
   int           errors = 0;
   int           init_words = 0;
   int           update_words = 0;
   int           sat_seen = 0;
   int           quiet_cycles = 0;

   second_order_complementary_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic longint clamp_q16(input longint v, inout logic hit);
      if (v > Q16_MAX) begin
         hit = 1'b1;
         return Q16_MAX;
      end
      if (v < Q16_MIN) begin
         hit = 1'b1;
         return Q16_MIN;
      end
      return v;
   endfunction

   function automatic fused_angle_type fuse_step(input logic kind, input logic ax,
         input logic signed [31:0] accel, input logic signed [31:0] rate,
         input logic [15:0] dt);
      fused_angle_type   r;
      longint            prev, integ, err, di, prop, term, da;
      longint unsigned   emag, tmag;
      logic [127:0]      wide;
      logic              clip;
      clip = 1'b0;
      if (kind == REQ_INIT) begin
         axis_angle[ax] = accel;
         axis_integ[ax] = rate;
      end else begin
         prev = axis_angle[ax];
         integ = axis_integ[ax];
         err = longint'(accel) - prev;
         emag = (err < 0) ? -err : err;
         // e*tc^2*dt back to Q16.16, rounded on the magnitude
         wide = 128'(emag) * tc_model * tc_model * dt + (128'd1 << 47);
         di = longint'(wide >> 48);
         if (err < 0) di = -di;
         integ = clamp_q16(integ + di, clip);
         prop = longint'((emag * 2 * tc_model + 64'd128) >> 8);
         if (err < 0) prop = -prop;
         term = integ + prop + longint'(rate);
         tmag = (term < 0) ? -term : term;
         wide = 128'(tmag) * dt + 128'h8000;
         da = longint'(wide >> 16);
         if (term < 0) da = -da;
         prev = clamp_q16(prev + da, clip);
         axis_integ[ax] = integ[31:0];
         axis_angle[ax] = prev[31:0];
      end
      r.angle = axis_angle[ax];
      r.axis = ax;
      r.sat = clip;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch @%0t: %s", $time, what);
   endtask

   task automatic add_row(input logic kind, input logic ax, input logic [31:0] accel,
         input logic [31:0] rate, input logic [15:0] dt, input logic fixed,
         input logic [31:0] want_angle);
      plan_row_type r;
      r = '{kind, ax, accel, rate, dt, fixed, want_angle, 1'b0};
      directed_rows.push_back(r);
   endtask

   // entered and left at a falling edge; valid stays up for a following word
   task automatic issue_word(input logic kind, input logic ax, input logic [31:0] accel,
         input logic [31:0] rate, input logic [15:0] dt, input logic fixed,
         input logic [31:0] want_angle, input logic want_sat);
      fused_angle_type next_result;
      while (!steady && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dt, rate, accel};
      req_tuser  <= {ax, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      next_result = fuse_step(kind, ax, accel, rate, dt);
      if (fixed) begin
         next_result.angle = want_angle;
         next_result.sat = want_sat;
      end
      pending_angles.push_back(next_result);
      if (kind == REQ_INIT) init_words++;
      else update_words++;
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_time_constant(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      tc_model = value;
   endtask

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 28);
   end

   always @(posedge clock) begin
      fused_angle_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tuser[1]) sat_seen++;
         if (pending_angles.size() == 0) begin
            report_mismatch($sformatf("unexpected word angle=%h user=%b",
                                      rsp_tdata, rsp_tuser));
         end else begin
            want = pending_angles.pop_front();
            if (rsp_tdata !== want.angle)
               report_mismatch($sformatf("angle %h, want %h", rsp_tdata, want.angle));
            if (rsp_tuser[0] !== want.axis)
               report_mismatch($sformatf("axis %b, want %b", rsp_tuser[0], want.axis));
            if (rsp_tuser[1] !== want.sat)
               report_mismatch($sformatf("saturated %b, want %b (angle %h)",
                                         rsp_tuser[1], want.sat, want.angle));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("second_order_complementary_filter_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      logic [15:0] tc_plan [PHASES];
      int          pick;
      logic        kind, ax;
      logic [31:0] accel, rate;
      logic [15:0] dt;

      tc_model = TC_RESET;
      axis_angle[0] = '0;
      axis_angle[1] = '0;
      axis_integ[0] = '0;
      axis_integ[1] = '0;
      tc_plan = '{16'h0000, 16'hFFFF, 16'h0100, 16'h0001, 16'h0000, TC_RESET,
                  16'h0000, 16'h0000};
      tc_plan[4] = 16'($urandom_range(0, 65535));
      tc_plan[6] = 16'($urandom_range(0, 4095));
      tc_plan[7] = 16'($urandom_range(0, 65535));

      // zero step after reset returns the cleared angle
      add_row(REQ_UPDATE, 1'b0, 32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1, 32'h0);
      add_row(REQ_UPDATE, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 1'b1, 32'h0);
      add_row(REQ_INIT,   1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b1,
              32'h7FFF_FFFF);
      add_row(REQ_INIT,   1'b1, 32'h8000_0000, 32'h8000_0000, 16'h0000, 1'b1,
              32'h8000_0000);
      // full-scale errors: clamp on both axes
      add_row(REQ_UPDATE, 1'b0, 32'h8000_0000, 32'h8000_0000, 16'hFFFF, 1'b0, 32'h0);
      add_row(REQ_UPDATE, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, 32'h0);
      add_row(REQ_UPDATE, 1'b0, 32'h1234_5678, 32'hDEAD_BEEF, 16'h0000, 1'b0, 32'h0);
      add_row(REQ_INIT,   1'b0, 32'h0001_0000, 32'h0000_0000, 16'h0000, 1'b1,
              32'h0001_0000);
      add_row(REQ_UPDATE, 1'b0, 32'h0002_0000, 32'h0000_0000, 16'h0001, 1'b0, 32'h0);
      add_row(REQ_UPDATE, 1'b0, 32'h0002_0000, 32'h0001_0000, 16'h0148, 1'b0, 32'h0);
      // integrator near the top, large positive error
      add_row(REQ_INIT,   1'b1, 32'h0000_0000, 32'h7FFF_FFF0, 16'h0000, 1'b1, 32'h0);
      add_row(REQ_UPDATE, 1'b1, 32'h7FFF_FFFF, 32'h0000_0000, 16'hFFFF, 1'b0, 32'h0);
      add_row(REQ_INIT,   1'b1, 32'hFFFF_0000, 32'hFFFE_0000, 16'h0000, 1'b1,
              32'hFFFF_0000);
      add_row(REQ_UPDATE, 1'b1, 32'hFFFF_0000, 32'hFFFE_0000, 16'h8000, 1'b0, 32'h0);
      add_row(REQ_UPDATE, 1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 16'h0001, 1'b0, 32'h0);
      add_row(REQ_UPDATE, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 1'b0, 32'h0);
      add_row(REQ_UPDATE, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 1'b0, 32'h0);
      add_row(REQ_INIT,   1'b0, 32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1, 32'h0);
      add_row(REQ_UPDATE, 1'b0, 32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b1, 32'h0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         issue_word(directed_rows[i].kind, directed_rows[i].ax, directed_rows[i].accel,
                    directed_rows[i].rate, directed_rows[i].dt, directed_rows[i].fixed,
                    directed_rows[i].want_angle, directed_rows[i].want_sat);

      for (int p = 0; p < PHASES; p++) begin
         hold_until_drained();
         write_time_constant(tc_plan[p]);
         steady = (p == 2);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n == PHASE_WORDS / 2) hold_until_drained();
            pick = $urandom_range(0, 99);
            ax = 1'($urandom_range(0, 1));
            kind = REQ_UPDATE;
            // plausible attitude: +-180 deg, +-512 deg/s, short steps
            accel = 32'($urandom_range(0, 360 << 16)) - (32'd180 << 16);
            rate = 32'($urandom_range(0, 1024 << 16)) - (32'd512 << 16);
            dt = 16'($urandom_range(0, 16'h0400));
            if (pick < 10) begin
               kind = REQ_INIT;
            end else if (pick < 25) begin
               accel = $urandom;
               rate = $urandom;
               dt = 16'($urandom);
            end else if (pick < 30) begin
               dt = (pick % 2) ? 16'hFFFF : 16'h0000;
            end
            issue_word(kind, ax, accel, rate, dt, 1'b0, 32'h0, 1'b0);
         end
      end
      steady = 1'b0;

      hold_until_drained();
      repeat (16) @(posedge clock);
      $display("run: %0d init and %0d update words over %0d time constant settings",
               init_words, update_words, PHASES + 1);
      $display("run: %0d results came back clipped, %0d mismatches", sat_seen, errors);
      if (errors == 0) begin
         $display("second_order_complementary_filter_tb: clean");
      end else begin
         $display("second_order_complementary_filter_tb: errors");
      end
      $finish;
   end

endmodule
